### design/tenh_pkg.sv
// Shared types and codes for the tiered energy next-hop table.
`timescale 1ns / 1ps

package tenh_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_HOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_BADTIER = 2'd3;

  localparam logic [1:0] TIER_NONE = 2'd0;
  localparam logic [1:0] TIER_ONE  = 2'd1;
  localparam logic [1:0] TIER_TWO  = 2'd2;

  localparam logic [15:0] HOP_COST_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  tier;
    logic [31:0] node_address;
    logic [31:0] node_energy;
  } tenh_req_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  result_tier;
    logic [31:0] result_address;
    logic [1:0]  status;
  } tenh_rsp_t;

  typedef struct packed {
    logic [1:0]  tier;
    logic [31:0] address;
    logic [31:0] energy;
  } tenh_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic rd;      // issue table read at scan index
    logic commit;  // write result, finish insert
  } tenh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_end;   // all filled entries have been read
    logic dv;        // read data in flight
    logic out_free;  // result register can take a new result
  } tenh_sts_t;

endpackage

### design/tenh_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tenh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/tenh_ctrl.sv
// Request sequencer for the tiered energy next-hop table.
`timescale 1ns / 1ps

module tenh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tenh_pkg::tenh_sts_t sts_i,
  output tenh_pkg::tenh_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = !sts_i.idx_end;
        if (sts_i.idx_end && !sts_i.dv) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan reads only while scanning, results only from the done state.
  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> state_q == S_SCAN)
    else $error("read issued outside scan");

  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit)
    else $error("two commits in a row");

  a_load_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("load did not start a scan");

endmodule

### design/tenh_dp.sv
// Table datapath: entry RAM, scan index, accumulators and result register.
`timescale 1ns / 1ps

module tenh_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tenh_pkg::tenh_req_t in_data_i,
  input  logic                cfg_valid_i,
  input  logic [15:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tenh_pkg::tenh_rsp_t out_data_o,
  input  tenh_pkg::tenh_cmd_t cmd_i,
  output tenh_pkg::tenh_sts_t sts_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = $bits(tenh_pkg::tenh_entry_t);

  tenh_pkg::tenh_req_t   req_q;
  tenh_pkg::tenh_rsp_t   rsp_q, rsp_d;
  tenh_pkg::tenh_entry_t rd_ent, wr_ent;
  logic [15:0]   hop_cost_q;
  logic [CW-1:0] count_q, idx_q;
  logic [AW-1:0] pix_q, waddr;
  logic          dv_q, out_valid_q, we;
  logic          dup_q, have_q;
  logic [31:0]   best_e_q, best_a_q, hop_e;
  logic [1:0]    low_q;
  logic          match, cand, take, full, ins_ok, hop_we;
  logic [EW-1:0] rdata;

  tenh_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_ent),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign rd_ent = rdata;
  assign full   = count_q == CW'(TABLE_ENTRIES);

  // Per-entry evaluation on the registered read data
  assign match = rd_ent.address == req_q.node_address;
  assign cand  = rd_ent.tier == req_q.tier && rd_ent.energy != 32'd0;
  assign take  = cand && (!have_q || rd_ent.energy > best_e_q ||
                 (rd_ent.energy == best_e_q && rd_ent.address < best_a_q));
  assign hop_e = (rd_ent.energy > {16'd0, hop_cost_q}) ?
                 rd_ent.energy - {16'd0, hop_cost_q} : 32'd0;

  assign hop_we = dv_q && req_q.operation == tenh_pkg::OP_HOP && match;
  assign ins_ok = req_q.operation == tenh_pkg::OP_INSERT &&
                  req_q.tier != tenh_pkg::TIER_NONE && !dup_q && !full;

  always_comb begin
    we     = 1'b0;
    waddr  = pix_q;
    wr_ent = rd_ent;
    if (hop_we) begin
      we            = 1'b1;
      wr_ent.energy = hop_e;
    end else if (cmd_i.commit && ins_ok) begin
      we             = 1'b1;
      waddr          = count_q[AW-1:0];
      wr_ent.tier    = req_q.tier;
      wr_ent.address = req_q.node_address;
      wr_ent.energy  = req_q.node_energy;
    end
  end

  always_comb begin
    rsp_d = '0;
    case (req_q.operation)
      tenh_pkg::OP_INSERT: begin
        if (req_q.tier == tenh_pkg::TIER_NONE) rsp_d.status = tenh_pkg::ST_BADTIER;
        else if (dup_q)                        rsp_d.status = tenh_pkg::ST_DUP;
        else if (full)                         rsp_d.status = tenh_pkg::ST_FULL;
        else                                   rsp_d.status = tenh_pkg::ST_OK;
      end
      tenh_pkg::OP_SELECT: begin
        if (req_q.tier != tenh_pkg::TIER_ONE && req_q.tier != tenh_pkg::TIER_TWO) begin
          rsp_d.status = tenh_pkg::ST_BADTIER;
        end else if (have_q) begin
          rsp_d.found          = 1'b1;
          rsp_d.result_address = best_a_q;
        end
      end
      tenh_pkg::OP_QUERY: begin
        rsp_d.found       = low_q != tenh_pkg::TIER_NONE;
        rsp_d.result_tier = low_q;
      end
      default: rsp_d = '0;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_cost_q  <= tenh_pkg::HOP_COST_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) hop_cost_q <= cfg_data_i;
      dv_q <= cmd_i.rd;
      if (cmd_i.load)    idx_q <= '0;
      else if (cmd_i.rd) idx_q <= idx_q + CW'(1);
      if (cmd_i.commit && ins_ok) count_q <= count_q + CW'(1);
      if (cmd_i.commit)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Request, accumulators and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) pix_q <= idx_q[AW-1:0];
    if (cmd_i.commit) rsp_q <= rsp_d;
    if (cmd_i.load) begin
      req_q  <= in_data_i;
      dup_q  <= 1'b0;
      have_q <= 1'b0;
      low_q  <= tenh_pkg::TIER_NONE;
    end else if (dv_q) begin
      if (rd_ent.tier == req_q.tier && match) dup_q <= 1'b1;
      if (take) begin
        have_q   <= 1'b1;
        best_e_q <= rd_ent.energy;
        best_a_q <= rd_ent.address;
      end
      if (match && (low_q == tenh_pkg::TIER_NONE || rd_ent.tier < low_q)) begin
        low_q <= rd_ent.tier;
      end
    end
  end

  assign sts_o.idx_end  = idx_q == count_q;
  assign sts_o.dv       = dv_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = rsp_q;

  a_commit_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && cmd_i.rd) |-> waddr != idx_q[AW-1:0])
    else $error("write back collides with scan read");

  a_scan_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> idx_q < count_q)
    else $error("read beyond filled entries");

endmodule

### design/tiered_energy_next_hop_table.sv
// Top level of the tiered energy next-hop table.
`timescale 1ns / 1ps

// Usage
// - Request channel in_valid_i/in_ready_o carries one tenh_req_t per transfer:
//   insert, select (highest nonzero energy in tier 1 or 2, lowest address on
//   ties), query (lowest tier holding an address) or hop (subtract hop cost
//   from every entry with the address, saturating at zero).
// - Result channel out_valid_o/out_ready_i returns exactly one tenh_rsp_t
//   per request, in request order.
// - Config channel cfg_valid_i/cfg_ready_o writes hop_cost (16 bit); always
//   ready. Write only while no request is in flight.
// - Table and scan: entries fill from slot 0 upward and are never removed, so a
//   fill count marks the valid ones. Every request scans the filled entries
//   through the single RAM read port, one per cycle, then waits in the done
//   state for a free result register. One request is in work at a time.
// - The result register lets a new request be taken while the previous
//   result waits; a stalled receiver holds the next result in the done
//   state until the register frees.
// - Reset empties the table at once (fill count to zero) and sets hop_cost
//   to 10. No clearing pass is needed.
module tiered_energy_next_hop_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tenh_pkg::tenh_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tenh_pkg::tenh_rsp_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  tenh_pkg::tenh_cmd_t cmd;
  tenh_pkg::tenh_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tenh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tenh_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
